// File: hw/rtl/jte_pkg.sv
package jte_pkg;

   // what the back part does with one byte unit
   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_RAW,
      KIND_BSL,
      KIND_ESC,
      KIND_CLOSE
   } kind_type;

   // one command from the front part: optional open quote, up to three held
   // bytes (escaped or raw), then one tail unit
   typedef struct packed {
      logic             open_q;
      logic [2:0][7:0]  held;
      logic [1:0]       held_n;
      logic             held_esc;
      kind_type         tail_kind;
      logic [7:0]       tail_byte;
   } cmd_type;

   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_ZERO   = 8'h30;

endpackage

// File: hw/rtl/jte_front.sv
module jte_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             action,
   input  logic [7:0]       text_byte,
   output logic             cmd_push,
   output jte_pkg::cmd_type cmd
);

   logic            open_ff, open_in;
   logic [2:0][7:0] held_ff, held_in;
   logic [1:0]      hc_ff, hc_in;
   logic [2:0]      sl_ff, sl_in;
   logic            cont;
   logic            do_fresh;

   // continuation check against the held lead byte
   always_comb begin
      cont = (text_byte & 8'hc0) == 8'h80;
      if (hc_ff == 2'd1) begin
         if (held_ff[0] == 8'he0 && text_byte < 8'ha0) cont = 1'b0;
         if (held_ff[0] == 8'hed && text_byte >= 8'ha0) cont = 1'b0;
         if (held_ff[0] == 8'hf0 && text_byte < 8'h90) cont = 1'b0;
         if (held_ff[0] == 8'hf4 && text_byte >= 8'h90) cont = 1'b0;
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.open_q    = !open_ff;
      cmd.held      = held_ff;
      cmd.held_n    = 2'd0;
      cmd.held_esc  = 1'b1;
      cmd.tail_kind = jte_pkg::KIND_NONE;
      cmd.tail_byte = text_byte;
      open_in       = open_ff;
      held_in       = held_ff;
      hc_in         = hc_ff;
      sl_in         = sl_ff;
      do_fresh      = 1'b0;
      if (accept) begin
         open_in = !action;
         if (action) begin
            cmd.held_n    = hc_ff;
            cmd.tail_kind = jte_pkg::KIND_CLOSE;
            hc_in         = 2'd0;
            sl_in         = 3'd0;
         end else if (hc_ff != 2'd0) begin
            if (cont && (3'(hc_ff) + 3'd1 >= sl_ff)) begin
               // sequence complete, pass through raw
               cmd.held_n    = hc_ff;
               cmd.held_esc  = 1'b0;
               cmd.tail_kind = jte_pkg::KIND_RAW;
               hc_in         = 2'd0;
               sl_in         = 3'd0;
            end else if (cont && hc_ff != 2'd3) begin
               held_in[hc_ff] = text_byte;
               hc_in          = hc_ff + 2'd1;
            end else begin
               cmd.held_n = hc_ff;
               hc_in      = 2'd0;
               sl_in      = 3'd0;
               do_fresh   = 1'b1;
            end
         end else begin
            do_fresh = 1'b1;
         end
         if (do_fresh) begin
            if (text_byte == jte_pkg::CH_QUOTE || text_byte == jte_pkg::CH_BSLASH) begin
               cmd.tail_kind = jte_pkg::KIND_BSL;
            end else if (text_byte < 8'h20) begin
               cmd.tail_kind = jte_pkg::KIND_ESC;
            end else if (text_byte < 8'h80) begin
               cmd.tail_kind = jte_pkg::KIND_RAW;
            end else if (text_byte >= 8'hc2 && text_byte <= 8'hdf) begin
               held_in[0] = text_byte;
               hc_in      = 2'd1;
               sl_in      = 3'd2;
            end else if (text_byte >= 8'he0 && text_byte <= 8'hef) begin
               held_in[0] = text_byte;
               hc_in      = 2'd1;
               sl_in      = 3'd3;
            end else if (text_byte >= 8'hf0 && text_byte <= 8'hf4) begin
               held_in[0] = text_byte;
               hc_in      = 2'd1;
               sl_in      = 3'd4;
            end else begin
               cmd.tail_kind = jte_pkg::KIND_ESC;
            end
         end
      end
   end

   assign cmd_push = accept && (cmd.open_q || cmd.held_n != 2'd0 ||
                                cmd.tail_kind != jte_pkg::KIND_NONE);

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      if (reset) begin
         open_ff <= 1'b0;
         hc_ff   <= 2'd0;
         sl_ff   <= 3'd0;
      end else begin
         open_ff <= open_in;
         hc_ff   <= hc_in;
         sl_ff   <= sl_in;
      end
   end

endmodule

// File: hw/rtl/jte_cmdq.sv
module jte_cmdq (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  jte_pkg::cmd_type wr_cmd,
   output logic             full,
   output logic             head_valid,
   output jte_pkg::cmd_type head,
   input  logic             rd_en
);

   jte_pkg::cmd_type               mem_ff [jte_pkg::CMDQ_DEPTH];
   logic [jte_pkg::CMDQ_AW-1:0]    wp_ff, rp_ff;
   logic [jte_pkg::CMDQ_AW:0]      cnt_ff, cnt_in;

   assign full       = cnt_ff == (jte_pkg::CMDQ_AW+1)'(jte_pkg::CMDQ_DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head       = mem_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (wr_en && !rd_en) cnt_in = cnt_ff + 1'b1;
      if (!wr_en && rd_en) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wp_ff] <= wr_cmd;
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= wp_ff + 1'b1;
         if (rd_en) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: hw/rtl/jte_back.sv
module jte_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  jte_pkg::cmd_type head,
   output logic             cmd_pop,
   output logic             empty,
   input  logic             pop,
   output logic [7:0]       out_byte,
   output logic             run_last,
   output logic             text_closed
);

   // units: 0 open quote, 1..3 held bytes, 4 tail
   function automatic logic [2:0] unit_len(jte_pkg::cmd_type c, logic [2:0] u);
      logic [2:0] len;
      len = 3'd0;
      case (u)
         3'd0: len = c.open_q ? 3'd1 : 3'd0;
         3'd1, 3'd2, 3'd3: begin
            if (3'(c.held_n) > u - 3'd1) len = c.held_esc ? 3'd6 : 3'd1;
         end
         3'd4: begin
            case (c.tail_kind)
               jte_pkg::KIND_RAW:   len = 3'd1;
               jte_pkg::KIND_BSL:   len = 3'd2;
               jte_pkg::KIND_ESC:   len = 3'd6;
               jte_pkg::KIND_CLOSE: len = 3'd1;
               default:             len = 3'd0;
            endcase
         end
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [2:0] first_from(jte_pkg::cmd_type c, logic [2:0] start);
      logic [2:0] res;
      res = 3'd5;
      for (int i = 4; i >= 0; i--) begin
         if (3'(i) >= start && unit_len(c, 3'(i)) != 3'd0) res = 3'(i);
      end
      return res;
   endfunction

   function automatic logic [7:0] hex_digit(logic [3:0] v);
      return (v < 4'd10) ? (8'h30 + 8'(v)) : (8'h57 + 8'(v));
   endfunction

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       closed;
   } obuf_type;

   logic [2:0]          unit_ff, unit_in;
   logic [2:0]          sub_ff, sub_in;
   logic [2:0]          eff_unit, next_unit, cur_len;
   logic [1:0]          held_idx;
   jte_pkg::kind_type   kind;
   logic [7:0]          ubyte;
   obuf_type            word;
   logic                emit, done;
   obuf_type            ob_ff [2];
   logic                ob_wp_ff, ob_rp_ff;
   logic [1:0]          ob_cnt_ff;

   assign eff_unit  = first_from(head, unit_ff);
   assign next_unit = first_from(head, eff_unit + 3'd1);
   assign cur_len   = unit_len(head, eff_unit);
   assign held_idx  = 2'(eff_unit - 3'd1);
   assign done      = (sub_ff + 3'd1 == cur_len) && next_unit == 3'd5;
   assign emit      = head_valid && ob_cnt_ff != 2'd2;
   assign cmd_pop   = emit && done;

   always_comb begin
      kind  = jte_pkg::KIND_CLOSE;
      ubyte = head.tail_byte;
      if (eff_unit == 3'd0) begin
         kind = jte_pkg::KIND_CLOSE;
      end else if (eff_unit == 3'd4) begin
         kind = head.tail_kind;
      end else begin
         kind  = head.held_esc ? jte_pkg::KIND_ESC : jte_pkg::KIND_RAW;
         ubyte = head.held[held_idx];
      end
   end

   always_comb begin
      word.last   = done;
      word.closed = eff_unit == 3'd4 && kind == jte_pkg::KIND_CLOSE;
      case (kind)
         jte_pkg::KIND_RAW: word.data = ubyte;
         jte_pkg::KIND_BSL: word.data = (sub_ff == 3'd0) ? jte_pkg::CH_BSLASH : ubyte;
         jte_pkg::KIND_ESC: begin
            case (sub_ff)
               3'd0:    word.data = jte_pkg::CH_BSLASH;
               3'd1:    word.data = jte_pkg::CH_U;
               3'd2:    word.data = jte_pkg::CH_ZERO;
               3'd3:    word.data = jte_pkg::CH_ZERO;
               3'd4:    word.data = hex_digit(ubyte[7:4]);
               default: word.data = hex_digit(ubyte[3:0]);
            endcase
         end
         default: word.data = jte_pkg::CH_QUOTE;
      endcase
   end

   always_comb begin
      unit_in = unit_ff;
      sub_in  = sub_ff;
      if (emit) begin
         if (sub_ff + 3'd1 != cur_len) begin
            unit_in = eff_unit;
            sub_in  = sub_ff + 3'd1;
         end else if (next_unit == 3'd5) begin
            unit_in = 3'd0;
            sub_in  = 3'd0;
         end else begin
            unit_in = next_unit;
            sub_in  = 3'd0;
         end
      end
   end

   assign empty       = ob_cnt_ff == 2'd0;
   assign out_byte    = ob_ff[ob_rp_ff].data;
   assign run_last    = ob_ff[ob_rp_ff].last;
   assign text_closed = ob_ff[ob_rp_ff].closed;

   always_ff @(posedge clock) begin
      if (emit) ob_ff[ob_wp_ff] <= word;
      if (reset) begin
         unit_ff   <= 3'd0;
         sub_ff    <= 3'd0;
         ob_wp_ff  <= 1'b0;
         ob_rp_ff  <= 1'b0;
         ob_cnt_ff <= 2'd0;
      end else begin
         unit_ff <= unit_in;
         sub_ff  <= sub_in;
         if (emit) ob_wp_ff <= !ob_wp_ff;
         if (pop && !empty) ob_rp_ff <= !ob_rp_ff;
         if (emit && !(pop && !empty)) ob_cnt_ff <= ob_cnt_ff + 2'd1;
         if (!emit && (pop && !empty)) ob_cnt_ff <= ob_cnt_ff - 2'd1;
      end
   end

endmodule

// File: hw/rtl/json_text_escaper_utf8_top.sv
// path: a word's first output word, when it has one, is registered in the command queue
//   and then in the output buffer before it shows on the result ports
// throughput: one input word per cycle while the queue has room; one output byte per
//   cycle while the output buffer has room, so an escape (six bytes) or a flushed
//   sequence holds the back part and back-pressures through the four-deep command queue
// reset: synchronous, active high; clears string state, queue and output buffer
module json_text_escaper_utf8_top (
   input  logic       clock,
   input  logic       reset,
   // input side, queue-style
   input  logic       push,
   output logic       full,
   input  logic       req_action,
   input  logic [7:0] req_text_byte,
   // result side, queue-style
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_text_closed
);

   logic             accept;
   logic             cmd_push;
   jte_pkg::cmd_type cmd;
   logic             q_full;
   logic             head_valid;
   jte_pkg::cmd_type head;
   logic             cmd_pop;

   // front accepts whenever the command queue has room
   assign full   = q_full;
   assign accept = push && !q_full;

   // front: classifies each byte, tracks utf-8 sequence state
   jte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .action    (req_action),
      .text_byte (req_text_byte),
      .cmd_push  (cmd_push),
      .cmd       (cmd)
   );

   // short queue decoupling classification from byte expansion
   jte_cmdq u_cmdq (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (cmd_push),
      .wr_cmd     (cmd),
      .full       (q_full),
      .head_valid (head_valid),
      .head       (head),
      .rd_en      (cmd_pop)
   );

   // back: expands each command into output bytes, one per cycle while the output buffer has room
   jte_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head        (head),
      .cmd_pop     (cmd_pop),
      .empty       (empty),
      .pop         (pop),
      .out_byte    (rsp_out_byte),
      .run_last    (rsp_run_last),
      .text_closed (rsp_text_closed)
   );

endmodule

// File: hw/rtl/jte_checker.sv
module jte_checker (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic       pop,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last,
   input logic       rsp_text_closed
);

   // nothing to deliver right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> empty) else $error("results pending after reset");

   // room for input right after reset
   a_room_after_reset: assert property (@(posedge clock)
      reset |=> !full) else $error("full after reset");

   // closing quote ends its word group and is a quote
   a_close_is_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_text_closed) |-> (rsp_run_last && rsp_out_byte == 8'h22))
      else $error("closing word malformed");

   // a waiting word holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_byte) &&
                            $stable(rsp_run_last) && $stable(rsp_text_closed)))
      else $error("waiting word changed");

endmodule

bind json_text_escaper_utf8_top jte_checker u_jte_checker (
   .clock           (clock),
   .reset           (reset),
   .full            (full),
   .empty           (empty),
   .pop             (pop),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_run_last    (rsp_run_last),
   .rsp_text_closed (rsp_text_closed)
);

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

   // action codes of the input word
   localparam logic ACT_TEXT = 1'b0;
   localparam logic ACT_END  = 1'b1;

   localparam int RANDOM_WORDS = 450;
   localparam int DRAIN_CYCLES = 24;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SHOWN_FAILS  = 10;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       full;
   logic       req_action = ACT_TEXT;
   logic [7:0] req_text_byte = 8'h00;
   logic       empty;
   logic       pop = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   logic       rsp_text_closed;

   json_text_escaper_utf8_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_action      (req_action),
      .req_text_byte   (req_text_byte),
      .empty           (empty),
      .pop             (pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_text_closed (rsp_text_closed)
   );

   // one input word waiting to be sent
   typedef struct {
      logic       act;
      logic [7:0] data;
   } text_word_type;

   // one output word of the quoted json text
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       text_closed;
   } json_word_type;

   text_word_type text_in_q[$];   // words still to be sent
   json_word_type json_out_q[$];  // expected output words, oldest first
   json_word_type step_q[$];      // output of the word being predicted

   int total_words = 1;
   int words_taken = 0;
   int fail_count  = 0;
   int cycle_count = 0;

   // escaper state as seen from outside
   logic       str_open = 1'b0;
   logic [7:0] held_seq[3];
   int         held_n  = 0;
   int         seq_len = 0;

   // ---------------------------------------------------------------------
   // clock
   // ---------------------------------------------------------------------
   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // prediction of the escaped text
   // ---------------------------------------------------------------------
   function automatic logic [7:0] hex_char(logic [3:0] n);
      return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h57 + 8'(n);
   endfunction

   task automatic emit(logic [7:0] b, logic closed);
      json_word_type w;
      w.out_byte    = b;
      w.run_last    = 1'b0;
      w.text_closed = closed;
      step_q = {step_q, w};
   endtask

   // six-byte \u00xx form, lowercase hex
   task automatic emit_escape(logic [7:0] b);
      emit(jte_pkg::CH_BSLASH, 1'b0);
      emit(jte_pkg::CH_U, 1'b0);
      emit(jte_pkg::CH_ZERO, 1'b0);
      emit(jte_pkg::CH_ZERO, 1'b0);
      emit(hex_char(b[7:4]), 1'b0);
      emit(hex_char(b[3:0]), 1'b0);
   endtask

   task automatic flush_pending();
      for (int k = 0; k < held_n; k++) emit_escape(held_seq[k]);
      held_n  = 0;
      seq_len = 0;
   endtask

   // does c extend the held sequence (shortest form, no surrogates, max U+10FFFF)
   function automatic bit extends_seq(logic [7:0] c);
      if (c[7:6] != 2'b10) return 1'b0;
      if (held_n == 1) begin
         if (held_seq[0] == 8'he0 && c < 8'ha0) return 1'b0;
         if (held_seq[0] == 8'hed && c >= 8'ha0) return 1'b0;
         if (held_seq[0] == 8'hf0 && c < 8'h90) return 1'b0;
         if (held_seq[0] == 8'hf4 && c >= 8'h90) return 1'b0;
      end
      return 1'b1;
   endfunction

   // a byte with no sequence pending
   task automatic take_fresh(logic [7:0] c);
      int len;
      len = 0;
      if (c == jte_pkg::CH_QUOTE || c == jte_pkg::CH_BSLASH) begin
         emit(jte_pkg::CH_BSLASH, 1'b0);
         emit(c, 1'b0);
      end else if (c < 8'h20) begin
         emit_escape(c);
      end else if (c < 8'h80) begin
         emit(c, 1'b0);
      end else begin
         if (c >= 8'hc2 && c <= 8'hdf) len = 2;
         else if (c >= 8'he0 && c <= 8'hef) len = 3;
         else if (c >= 8'hf0 && c <= 8'hf4) len = 4;
         if (len == 0) begin
            emit_escape(c);
         end else begin
            held_seq[0] = c;
            held_n      = 1;
            seq_len     = len;
         end
      end
   endtask

   // expected output words for one accepted input word
   task automatic predict_escaped_text(logic act, logic [7:0] c);
      step_q.delete();
      // opening quote comes ahead of anything else in a new string
      if (!str_open) begin
         emit(jte_pkg::CH_QUOTE, 1'b0);
         str_open = 1'b1;
      end
      if (act == ACT_END) begin
         flush_pending();
         emit(jte_pkg::CH_QUOTE, 1'b1);
         str_open = 1'b0;
      end else if (held_n > 0) begin
         if (extends_seq(c)) begin
            if (held_n + 1 >= seq_len) begin
               // sequence complete: held bytes and this one go out raw
               for (int k = 0; k < held_n; k++) emit(held_seq[k], 1'b0);
               emit(c, 1'b0);
               held_n  = 0;
               seq_len = 0;
            end else begin
               held_seq[held_n] = c;
               held_n++;
            end
         end else begin
            // broken sequence: escape what was held, then start over with c
            flush_pending();
            take_fresh(c);
         end
      end else begin
         take_fresh(c);
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].run_last = 1'b1;
      foreach (step_q[k]) json_out_q = {json_out_q, step_q[k]};
   endtask

   // ---------------------------------------------------------------------
   // idle rates per phase: receiver lazy first, then sender, then neither
   // ---------------------------------------------------------------------
   function automatic int send_idle_pct();
      if (words_taken < total_words / 3) return 33;
      if (words_taken < (2 * total_words) / 3) return 78;
      return 0;
   endfunction

   function automatic int recv_idle_pct();
      if (words_taken < total_words / 3) return 78;
      if (words_taken < (2 * total_words) / 3) return 33;
      return 0;
   endfunction

   // ---------------------------------------------------------------------
   // driver: push words from the pending queue, predict on acceptance
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            predict_escaped_text(req_action, req_text_byte);
            words_taken++;
            text_in_q.delete(0);
         end
         // a word that was offered but refused stays on the port
         if (push && full) begin
            push <= 1'b1;
         end else if (text_in_q.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
            push          <= 1'b1;
            req_action    <= text_in_q[0].act;
            req_text_byte <= text_in_q[0].data;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: compare each popped word with the oldest expectation
   // ---------------------------------------------------------------------
   task automatic note_failure(string msg);
      fail_count++;
      if (fail_count <= SHOWN_FAILS) $display("%0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (json_out_q.size() == 0) begin
               note_failure($sformatf("unexpected word: byte %h last %b closed %b",
                  rsp_out_byte, rsp_run_last, rsp_text_closed));
            end else begin
               if (rsp_out_byte !== json_out_q[0].out_byte
                   || rsp_run_last !== json_out_q[0].run_last
                   || rsp_text_closed !== json_out_q[0].text_closed)
                  note_failure($sformatf(
                     "mismatch: expected byte %h last %b closed %b, got %h %b %b",
                     json_out_q[0].out_byte, json_out_q[0].run_last,
                     json_out_q[0].text_closed, rsp_out_byte, rsp_run_last,
                     rsp_text_closed));
               json_out_q.delete(0);
            end
         end
         pop <= ($urandom_range(99) >= recv_idle_pct());
      end
   end

   // ---------------------------------------------------------------------
   // run limit
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_text(logic [7:0] b);
      text_word_type w;
      w.act     = ACT_TEXT;
      w.data    = b;
      text_in_q = {text_in_q, w};
   endtask

   // end of string; the byte lane carries junk since it is ignored
   task automatic add_end();
      text_word_type w;
      w.act     = ACT_END;
      w.data    = 8'($urandom_range(255));
      text_in_q = {text_in_q, w};
   endtask

   function automatic logic [7:0] lead_for(int len);
      if (len == 2) return 8'($urandom_range(8'hc2, 8'hdf));
      if (len == 3) begin
         // favor the leads with a narrowed second byte
         case ($urandom_range(3))
            0: return 8'he0;
            1: return 8'hed;
            default: return 8'($urandom_range(8'he0, 8'hef));
         endcase
      end
      return 8'($urandom_range(8'hf0, 8'hf4));
   endfunction

   function automatic logic [7:0] good_second(logic [7:0] lead);
      case (lead)
         8'he0: return 8'($urandom_range(8'ha0, 8'hbf));
         8'hed: return 8'($urandom_range(8'h80, 8'h9f));
         8'hf0: return 8'($urandom_range(8'h90, 8'hbf));
         8'hf4: return 8'($urandom_range(8'h80, 8'h8f));
         default: return 8'($urandom_range(8'h80, 8'hbf));
      endcase
   endfunction

   function automatic logic [7:0] bad_second(logic [7:0] lead);
      case (lead)
         8'he0: return 8'($urandom_range(8'h80, 8'h9f));
         8'hed: return 8'($urandom_range(8'ha0, 8'hbf));
         8'hf0: return 8'($urandom_range(8'h80, 8'h8f));
         8'hf4: return 8'($urandom_range(8'h90, 8'hbf));
         default: begin
            if ($urandom_range(1)) return 8'($urandom_range(1, 8'h7f));
            return 8'($urandom_range(8'hc0, 8'hff));
         end
      endcase
   endfunction

   // a multi-byte sequence; keep says how many of its bytes are sent
   task automatic add_sequence(int len, int keep, bit break_it);
      logic [7:0] lead;
      lead = lead_for(len);
      queue_text(lead);
      if (keep < 2) return;
      queue_text(break_it ? bad_second(lead) : good_second(lead));
      for (int k = 2; k < keep; k++) queue_text(8'($urandom_range(8'h80, 8'hbf)));
   endtask

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int units;
      int pick;
      int len;

      // directed: empty string, escape classes, sequence edges
      add_end();                // no byte since the last end: two quotes
      queue_text(8'h00);        // zero byte is a plain control byte
      queue_text(8'h1f);
      queue_text(jte_pkg::CH_QUOTE);
      queue_text(jte_pkg::CH_BSLASH);
      queue_text(8'h7f);
      queue_text(8'hc2);        // smallest two-byte form
      queue_text(8'h80);
      queue_text(8'he0);        // overlong three-byte form breaks
      queue_text(8'h9f);
      queue_text(8'hf4);        // top of the code space
      queue_text(8'h8f);
      queue_text(8'hbf);
      queue_text(8'hbf);
      queue_text(8'hff);        // never a lead
      queue_text(8'hed);        // string ends with a sequence still held
      queue_text(8'h9f);
      add_end();
      queue_text(8'hf0);        // three held bytes flushed, then a control byte
      queue_text(8'h90);
      queue_text(8'h80);
      queue_text(8'h01);
      queue_text(8'hc0);
      add_end();

      // random strings: mostly well-formed utf-8, some broken or stray bytes
      while (text_in_q.size() < RANDOM_WORDS) begin
         units = $urandom_range(0, 10);
         for (int u = 0; u < units; u++) begin
            pick = $urandom_range(99);
            len  = $urandom_range(2, 4);
            if (pick < 4) queue_text($urandom_range(1) ? jte_pkg::CH_QUOTE : jte_pkg::CH_BSLASH);
            else if (pick < 30) queue_text(8'($urandom_range(8'h20, 8'h7f)));
            else if (pick < 40) queue_text(8'($urandom_range(1, 8'h1f)));
            else if (pick < 72) add_sequence(len, len, 1'b0);
            else if (pick < 82) add_sequence(len, $urandom_range(1, len - 1), 1'b0);
            else if (pick < 90) add_sequence(len, 2, 1'b1);
            else queue_text(8'($urandom_range(8'h80, 8'hff)));
         end
         add_end();
      end
      total_words = text_in_q.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // all words accepted, then all expected output seen, then a quiet tail
      while (text_in_q.size() != 0 || push) @(posedge clock);
      while (json_out_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && json_out_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
